// ===== design/framed_packet_receiver_assert.svh =====
// Assertion macros for the framed packet receiver RTL; included by fpr_back.
// Expects signals named clk and rst_n in the including module's scope.
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define FPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpr assertion failed");

// Check that a condition never holds outside reset.
`define FPR_NEVER(lbl, cond) `FPR_ASSERT(lbl, !(cond))

`endif

// ===== design/fpr_pkg.sv =====
// Shared types and constants for the framed packet receiver.
// No dependencies.
package fpr_pkg;

    localparam int FPR_MAX_PAYLOAD = 32;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 7;
    localparam int IDX_W           = 6;
    localparam int OUT_DATA_W      = 24;
    localparam int CFG_IDX_W       = 2;
    localparam int QDEPTH          = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN = 2'd2;

    localparam logic [BYTE_W-1:0] START_RESET  = 8'd2;
    localparam logic [BYTE_W-1:0] STOP_RESET   = 8'd3;
    localparam logic [LEN_W-1:0]  MAXLEN_RESET = 7'd32;

    // Descriptor of one accepted frame passed from parser to emitter.
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] length;
    } fpr_frame_t;

endpackage

// ===== design/fpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fpr_queue.sv =====
// Two-entry queue of frame descriptors between parser and emitter.
// Depends on fpr_pkg.
module fpr_queue
    import fpr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fpr_frame_t       push,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [LEN_W-1:0] head_length
);

    logic [LEN_W-1:0] entry_reg [QDEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full        = (count_reg == 2'(QDEPTH));
    assign not_empty   = (count_reg != 2'd0);
    assign head_length = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.length;
        end
    end

endmodule

// ===== design/fpr_front.sv =====
// Frame parser: hunts for the start byte, checks length, stores payload
// and checks XOR and stop byte. Depends on fpr_pkg.
module fpr_front
    import fpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = FPR_MAX_PAYLOAD,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 back_busy,
    input  logic                 q_full,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [BYTE_W-1:0]    wr_data,
    output fpr_frame_t           push
);

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_CHECK  = 5'b01000,
        PH_STOP   = 5'b10000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] start_reg, stop_reg;
    logic [LEN_W-1:0]  max_len_reg;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic              check_ok_reg, check_ok_next;
    logic [LEN_W-1:0]  limit;
    logic [LEN_W-1:0]  count_inc;
    logic              accept;

    // Hold data bytes while the emitter still reads the payload store, and stop bytes while the queue is full.
    assign s_tready = !((phase_reg == PH_DATA) && back_busy)
                      && !((phase_reg == PH_STOP) && q_full);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign limit = (max_len_reg > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                       : max_len_reg;
    assign count_inc = count_reg + LEN_W'(1);

    assign wr_en   = accept && (phase_reg == PH_DATA)
                     && (count_reg < LEN_W'(MAX_PAYLOAD));
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = s_tdata;

    always_comb
    begin
        phase_next    = phase_reg;
        exp_len_next  = exp_len_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        check_ok_next = check_ok_reg;
        push.valid    = 1'b0;
        push.length   = exp_len_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    if ((s_tdata != '0) && (s_tdata <= {1'b0, limit}))
                    begin
                        exp_len_next = s_tdata[LEN_W-1:0];
                        count_next   = '0;
                        xor_next     = '0;
                        phase_next   = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    xor_next   = xor_reg ^ s_tdata;
                    count_next = count_inc;
                    if (count_inc >= exp_len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    check_ok_next = (s_tdata == xor_reg);
                    phase_next    = PH_STOP;
                end
                PH_STOP:
                begin
                    push.valid    = (s_tdata == stop_reg) && check_ok_reg;
                    check_ok_next = 1'b0;
                    phase_next    = PH_HUNT;
                end
                default:
                begin
                    phase_next = (s_tdata == start_reg) ? PH_LENGTH : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            exp_len_reg  <= '0;
            count_reg    <= '0;
            xor_reg      <= '0;
            check_ok_reg <= 1'b0;
            start_reg    <= START_RESET;
            stop_reg     <= STOP_RESET;
            max_len_reg  <= MAXLEN_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            exp_len_reg  <= exp_len_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            check_ok_reg <= check_ok_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START)
                begin
                    start_reg <= cfg_data;
                end
                else if (cfg_index == CFG_STOP)
                begin
                    stop_reg <= cfg_data;
                end
                else if (cfg_index == CFG_MAXLEN)
                begin
                    max_len_reg <= cfg_data[LEN_W-1:0];
                end
            end
        end
    end

endmodule

// ===== design/fpr_back.sv =====
// Payload emitter: takes frame descriptors, reads the payload store and
// streams one result per byte through an output register. Depends on fpr_pkg.
module fpr_back
    import fpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = FPR_MAX_PAYLOAD,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  logic [LEN_W-1:0]      q_length,
    output logic                  q_pop,
    output logic                  busy,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    input  logic [BYTE_W-1:0]     rd_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

`include "framed_packet_receiver_assert.svh"

    logic             active_reg, active_next;
    logic [LEN_W-1:0] cur_len_reg;
    logic [LEN_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [LEN_W-1:0] pend_len_reg;
    logic             pend_last_reg;
    logic             out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_last_reg;
    logic             load;
    logic             last_issue;
    logic [LEN_W-1:0] rd_idx_inc;

    // RAM read data waits in the RAM output register until the output
    // register frees up.
    assign load       = pend_reg && (!out_valid_reg || m_tready);
    assign rd_en      = active_reg && (!pend_reg || load);
    assign rd_addr    = rd_idx_reg[AW-1:0];
    assign rd_idx_inc = rd_idx_reg + LEN_W'(1);
    assign last_issue = rd_en && (rd_idx_inc == cur_len_reg);
    assign q_pop      = !active_reg && q_valid;
    assign busy       = active_reg || q_valid;

    always_comb
    begin
        active_next = active_reg;
        rd_idx_next = rd_idx_reg;
        if (q_pop)
        begin
            active_next = 1'b1;
            rd_idx_next = '0;
        end
        else if (rd_en)
        begin
            rd_idx_next = rd_idx_inc;
            if (last_issue)
            begin
                active_next = 1'b0;
            end
        end

        priority if (rd_en)
        begin
            pend_next = 1'b1;
        end
        else if (load)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end

        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_len_reg <= q_length;
        end
        if (rd_en)
        begin
            pend_idx_reg  <= rd_idx_reg[IDX_W-1:0];
            pend_len_reg  <= cur_len_reg;
            pend_last_reg <= last_issue;
        end
        if (load)
        begin
            out_byte_reg <= rd_data;
            out_idx_reg  <= pend_idx_reg;
            out_len_reg  <= pend_len_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - BYTE_W - IDX_W - LEN_W){1'b0}},
                       out_len_reg, out_idx_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    `FPR_ASSERT(a_read_in_frame, rd_en |-> (rd_idx_reg < cur_len_reg))
    `FPR_NEVER(a_pop_while_active, q_pop && active_reg)
    `FPR_ASSERT(a_last_at_end,
        (m_tvalid && m_tlast) |-> ((LEN_W'(out_idx_reg) + LEN_W'(1)) == out_len_reg))
    `FPR_ASSERT(a_stall_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

// ===== design/framed_packet_receiver.sv =====
// Framed packet receiver top level: parser, descriptor queue, payload
// store and emitter. Depends on fpr_pkg, fpr_front, fpr_queue, fpr_ram, fpr_back.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one received byte per transaction.
//   Frames are START, LENGTH, PAYLOAD[LENGTH], CHECK (XOR of payload), STOP.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write start byte (0), stop byte (1)
//   and max length (2); cfg_ready is always high. Write only while idle.
//   m_tvalid/m_tready/m_tdata/m_tlast deliver one transaction per payload
//   byte of a good frame, tlast on the final byte. Bad frames vanish.
// Timing:
//   One input byte per cycle is accepted while s_tready is high. m_tvalid rises
//   once the stop byte's descriptor has passed the queue, the emitter's active flag,
//   the RAM read register and the output register, then one result per cycle while
//   m_tready stays high; the single-port read of the payload store paces it.
//   Payload bytes of the next frame are held off (s_tready low) until the previous frame
//   has been read out of the store; delimiter and length bytes still go through.
// Reset:
//   rst_n clears the parser to hunting and restores register defaults.
//   A stalled receiver holds m_tdata; the payload store keeps its contents.
module framed_packet_receiver
    import fpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = FPR_MAX_PAYLOAD
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [7:0] payload_byte, [13:8] byte_index,
                                              // [20:14] frame_length, [23:21] zero
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    fpr_frame_t       push;
    logic             q_full, q_valid, q_pop, back_busy;
    logic [LEN_W-1:0] q_length;
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data;

    fpr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .back_busy (back_busy),
        .q_full    (q_full),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push)
    );

    fpr_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pop         (q_pop),
        .full        (q_full),
        .not_empty   (q_valid),
        .head_length (q_length)
    );

    fpr_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PAYLOAD)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fpr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_length (q_length),
        .q_pop    (q_pop),
        .busy     (back_busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/framed_packet_receiver_tb.sv =====
// Self-checking testbench for framed_packet_receiver: byte stream in, payload beats out.
// Predicts the frame parser in a scoreboard class and checks every emitted beat in order.
// Depends on fpr_pkg and the framed_packet_receiver RTL.
`timescale 1ns / 100ps

module framed_packet_receiver_tb;
    import fpr_pkg::*;

    localparam int MAXP = FPR_MAX_PAYLOAD;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LENGTH = 3'd1,
        PH_DATA   = 3'd2,
        PH_CHECK  = 3'd3,
        PH_STOP   = 3'd4
    } parse_phase_e;

    typedef enum int {
        FRAME_OK        = 0,
        FRAME_BAD_LEN   = 1,
        FRAME_BAD_CHECK = 2,
        FRAME_BAD_STOP  = 3
    } frame_fault_e;

    typedef struct {
        logic [7:0] payload;
        logic [5:0] pos;
        logic [6:0] flen;
        logic       last;
    } payload_beat_t;

    class payload_tracker;
        logic [7:0]    start_byte;
        logic [7:0]    stop_byte;
        logic [6:0]    max_length;
        parse_phase_e  phase;
        logic [7:0]    frame_bytes [MAXP];
        logic [6:0]    want_len;
        logic [6:0]    got_count;
        logic [7:0]    xor_acc;
        logic          check_ok;
        payload_beat_t due_payload [$];
        int            errors;

        function new();
            start_byte = START_RESET;
            stop_byte  = STOP_RESET;
            max_length = MAXLEN_RESET;
            phase      = PH_HUNT;
            want_len   = '0;
            got_count  = '0;
            xor_acc    = '0;
            check_ok   = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_START:  start_byte = val;
                CFG_STOP:   stop_byte  = val;
                CFG_MAXLEN: max_length = val[6:0];
                default: ;
            endcase
        endfunction

        function int accepted_limit();
            return (int'(max_length) > MAXP) ? MAXP : int'(max_length);
        endfunction

        // Advance the parser by one received byte; queue the beats of a good frame.
        function void note_rx_byte(logic [7:0] b);
            payload_beat_t beat;
            int            n;
            case (phase)
                PH_LENGTH:
                begin
                    if (b != 8'd0 && int'(b) <= accepted_limit())
                    begin
                        want_len  = b[6:0];
                        got_count = '0;
                        xor_acc   = '0;
                        phase     = PH_DATA;
                    end
                    else
                        phase = PH_HUNT;
                end
                PH_DATA:
                begin
                    if (int'(got_count) < MAXP)
                        frame_bytes[got_count] = b;
                    xor_acc   = xor_acc ^ b;
                    got_count = got_count + 7'd1;
                    if (got_count >= want_len)
                        phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    check_ok = (b == xor_acc);
                    phase    = PH_STOP;
                end
                PH_STOP:
                begin
                    if (b == stop_byte && check_ok)
                    begin
                        n = (int'(want_len) > MAXP) ? MAXP : int'(want_len);
                        for (int i = 0; i < n; i++)
                        begin
                            beat.payload = frame_bytes[i];
                            beat.pos     = 6'(i);
                            beat.flen    = 7'(n);
                            beat.last    = (i == n - 1);
                            due_payload.push_back(beat);
                        end
                    end
                    check_ok = 1'b0;
                    phase    = PH_HUNT;
                end
                default:
                    phase = (b == start_byte) ? PH_LENGTH : PH_HUNT;
            endcase
        endfunction

        function void check_beat(logic [OUT_DATA_W-1:0] data, logic last);
            payload_beat_t want;
            if (due_payload.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: byte %02h pos %0d len %0d last %0b",
                             data[7:0], data[13:8], data[20:14], last);
                return;
            end
            want = due_payload.pop_front();
            if (data[7:0] !== want.payload || data[13:8] !== want.pos ||
                data[20:14] !== want.flen || last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"beat mismatch: expected byte %02h pos %0d len %0d last %0b,",
                              " got byte %02h pos %0d len %0d last %0b"},
                             want.payload, want.pos, want.flen, want.last,
                             data[7:0], data[13:8], data[20:14], last);
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;    // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // [7:0] payload_byte, [13:8] byte_index,
                                              // [20:14] frame_length, [23:21] zero
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_START;
    logic [BYTE_W-1:0]     cfg_data  = '0;

    payload_tracker sb;
    int             rx_count   = 0;
    int             burst_left = 0;
    int             stall_left = 0;
    logic [15:0]    cyc        = '0;

    framed_packet_receiver #(
        .MAX_PAYLOAD(MAXP)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver stalls: free-running, short stalls, long stalls, alternate cycles.
    always @(posedge clk)
    begin
        cyc <= cyc + 16'd1;
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            case (cyc[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1:
                    if ($urandom_range(0, 3) == 0)
                    begin
                        m_tready   <= 1'b0;
                        stall_left <= $urandom_range(0, 2);
                    end
                    else
                        m_tready <= 1'b1;
                2'd2:
                    if ($urandom_range(0, 15) == 0)
                    begin
                        m_tready   <= 1'b0;
                        stall_left <= $urandom_range(3, 23);
                    end
                    else
                        m_tready <= 1'b1;
                default: m_tready <= cyc[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tlast);
    end

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        rx_count++;
        sb.note_rx_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] body [$], input frame_fault_e fault);
        logic [7:0] xsum;
        int         lim;
        xsum = '0;
        foreach (body[i])
            xsum = xsum ^ body[i];
        send_byte(sb.start_byte);
        if (fault == FRAME_BAD_LEN)
        begin
            lim = sb.accepted_limit();
            send_byte(($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(lim + 1, 255)));
            return;
        end
        send_byte(8'(body.size()));
        foreach (body[i])
            send_byte(body[i]);
        send_byte((fault == FRAME_BAD_CHECK) ? (xsum ^ 8'($urandom_range(1, 255))) : xsum);
        send_byte((fault == FRAME_BAD_STOP) ? (sb.stop_byte ^ 8'($urandom_range(1, 255)))
                                            : sb.stop_byte);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every predicted beat is out, then let the parser settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.due_payload.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Mostly well-formed frames with random payload; the rest noise and broken frames.
    task automatic random_traffic(input int n);
        int         target;
        int         lim;
        int         len;
        int         pick;
        bit         first;
        logic [7:0] body [$];
        target = rx_count + n;
        first  = 1'b1;
        lim    = sb.accepted_limit();
        if (lim == 0)
            lim = 1;
        while (rx_count < target)
        begin
            pick  = first ? 9 : $urandom_range(0, 9);
            len   = (first || $urandom_range(0, 7) == 0) ? lim
                                                         : $urandom_range(1, (lim < 8) ? lim : 8);
            first = 1'b0;
            body.delete();
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            if (pick == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            else if (pick <= 3)
                send_frame(body, frame_fault_e'(pick));
            else
                send_frame(body, FRAME_OK);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_START, START_RESET);
        write_reg(CFG_STOP, STOP_RESET);
        write_reg(CFG_MAXLEN, {1'b0, MAXLEN_RESET});

        // Directed: noise extremes, start byte inside payload, rejected lengths, bad endings.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame('{8'h00}, FRAME_OK);
        send_frame('{START_RESET, STOP_RESET, 8'hFF}, FRAME_OK);
        send_byte(sb.start_byte);
        send_byte(8'd0);
        send_byte(sb.start_byte);
        send_byte(8'(MAXP + 1));
        send_frame('{8'hA5}, FRAME_BAD_CHECK);
        send_frame('{8'h5A}, FRAME_BAD_STOP);
        random_traffic(45);
        wait_drained();

        write_reg(CFG_START, 8'hFF);
        write_reg(CFG_STOP, 8'h00);
        write_reg(CFG_MAXLEN, 8'd1);
        random_traffic(15);
        wait_drained();

        // Limit above the buffer depth saturates; the unused index must change nothing.
        write_reg(CFG_START, 8'h00);
        write_reg(CFG_STOP, 8'hFF);
        write_reg(CFG_MAXLEN, 8'hFF);
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        random_traffic(20);
        wait_drained();

        write_reg(CFG_MAXLEN, 8'd0);
        random_traffic(10);
        wait_drained();

        write_reg(CFG_START, 8'($urandom_range(0, 255)));
        write_reg(CFG_STOP, 8'($urandom_range(0, 255)));
        write_reg(CFG_MAXLEN, 8'd64);
        random_traffic(30);
        wait_drained();

        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("framed_packet_receiver_tb: clean");
        else
            $display("framed_packet_receiver_tb: errors");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("framed_packet_receiver_tb: errors");
        $finish;
    end

endmodule
